@@ rtl/hvd_pkg.sv @@
package hvd_pkg;

   // Request kinds carried in the req_type field.
   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam int NUM_NAMES = 9;
   localparam int NAME_MAX  = 10;

   localparam logic [7:0] BYTE_LOW_LIMIT  = 8'h21;
   localparam logic [7:0] BYTE_HIGH_LIMIT = 8'h7e;
   localparam logic [7:0] BYTE_QUOTE      = 8'h22;
   localparam logic [7:0] BYTE_TAB        = 8'h09;

   localparam logic [7:0] NAME_TEXT [NUM_NAMES][NAME_MAX] = '{
      '{"n", "a", "m", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"p", "r", "o", "c", "t", "i", "t", "l", "e", 8'h00},
      '{"p", "a", "t", "h", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"d", "i", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"c", "o", "m", "m", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"o", "c", "o", "m", "m", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"d", "a", "t", "a", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"o", "l", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"n", "e", "w", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{
      4'd4, 4'd9, 4'd4, 4'd3, 4'd4, 4'd5, 4'd4, 4'd3, 4'd3
   };

   // Range restriction on the first continuation byte of a UTF-8 sequence.
   typedef enum logic [2:0] {
      RULE_NONE,
      RULE_A0_BF,
      RULE_80_9F,
      RULE_90_BF,
      RULE_80_8F
   } hvd_utf8_rule_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] in_char;
      logic       quoted;
   } hvd_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_verdict;
      logic       accepted;
   } hvd_rsp_type;

   // Hex digit value; the flag is low for a character that is no hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= "0" && c <= "9") begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= "a" && c <= "f") begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= "A" && c <= "F") begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

@@ rtl/audit_hex_value_decoder.sv @@
// Hex value decoder for audit-style key-value records.
//
// Request channel (req_valid, req_stall, req_payload): one character per
// request, tagged as key character, value character or end of value.
// Response channel (rsp_valid, rsp_stall, rsp_payload): one decoded byte for
// each completed pair of hex digits while the value has held no invalid digit,
// and one verdict per end marker. Key and lone value characters produce no response.
//
// A request taken enters the input register; it is decoded and its response
// loaded into the output register once that register is empty or its
// response is being taken, so every response comes from a register. One
// request is taken per cycle while req_stall is low; the whole decode is a
// single pass of logic between the input register and the output register.
//
// While the receiver stalls, the output register holds its response and the
// input register holds the next request; one more request lands in a skid
// register, after which req_stall rises (it is driven from a register).
// Reset empties all registers and returns the parser to the start of a key.
module audit_hex_value_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hvd_pkg::hvd_req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hvd_pkg::hvd_rsp_type rsp_payload
);
   import hvd_pkg::*;

   // Request registers.
   logic        in_valid_ff, in_valid_in;
   hvd_req_type in_data_ff, in_data_in;
   logic        skid_valid_ff, skid_valid_in;
   hvd_req_type skid_data_ff, skid_data_in;

   // Response register.
   logic        out_valid_ff, out_valid_in;
   hvd_rsp_type out_data_ff, out_data_in;

   // Parser state.
   logic [NUM_NAMES-1:0] cand_ff, cand_in;
   logic [3:0]           key_pos_ff, key_pos_in;
   logic                 a_digit_ff, a_digit_in;
   logic                 in_value_ff, in_value_in;
   logic [3:0]           high_ff, high_in;
   logic                 have_high_ff, have_high_in;
   logic                 nonempty_ff, nonempty_in;
   logic                 hex_err_ff, hex_err_in;
   logic                 enc_ff, enc_in;
   logic [1:0]           pend_ff, pend_in;
   hvd_utf8_rule_type    rule_ff, rule_in;
   logic                 utf_err_ff, utf_err_in;

   logic        req_take;
   logic        advance;
   logic        has_result;
   hvd_rsp_type result;
   logic [4:0]  digit;
   logic [7:0]  dec_byte;
   logic [7:0]  lo_bound;
   logic [7:0]  hi_bound;
   logic        as_lead;
   logic        matched;
   logic [7:0]  name_ch;

   assign req_stall   = skid_valid_ff;
   assign req_take    = req_valid && !req_stall;
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // Input register and skid register.
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_data_in    = in_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (advance || !in_valid_ff) begin
         if (skid_valid_ff) begin
            in_valid_in   = 1'b1;
            in_data_in    = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            in_valid_in = req_take;
            in_data_in  = req_payload;
         end
      end else if (req_take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = req_payload;
      end
   end

   // Decode of the request in the input register.
   always_comb begin
      cand_in      = cand_ff;
      key_pos_in   = key_pos_ff;
      a_digit_in   = a_digit_ff;
      in_value_in  = in_value_ff;
      high_in      = high_ff;
      have_high_in = have_high_ff;
      nonempty_in  = nonempty_ff;
      hex_err_in   = hex_err_ff;
      enc_in       = enc_ff;
      pend_in      = pend_ff;
      rule_in      = rule_ff;
      utf_err_in   = utf_err_ff;
      has_result   = 1'b0;
      result       = '0;
      digit        = hex_digit(in_data_ff.in_char);
      dec_byte     = {high_ff, digit[3:0]};
      lo_bound     = 8'h80;
      hi_bound     = 8'hbf;
      as_lead      = 1'b0;
      matched      = 1'b0;
      name_ch      = 8'h00;

      unique case (in_data_ff.req_type)
         KIND_KEY: begin
            if (!in_value_ff) begin
               for (int i = 0; i < NUM_NAMES; i++) begin
                  name_ch = (key_pos_ff < 4'(NAME_MAX)) ? NAME_TEXT[i][key_pos_ff] : 8'h00;
                  if (key_pos_ff >= NAME_LEN[i] || name_ch != in_data_ff.in_char) begin
                     cand_in[i] = 1'b0;
                  end
               end
               if (key_pos_ff == 4'd0) begin
                  a_digit_in = (in_data_ff.in_char == "a");
               end else if (key_pos_ff == 4'd1) begin
                  a_digit_in = a_digit_ff && in_data_ff.in_char >= "0" &&
                               in_data_ff.in_char <= "9";
               end
               if (key_pos_ff != 4'd15) begin
                  key_pos_in = key_pos_ff + 4'd1;
               end
            end
         end
         KIND_VALUE: begin
            in_value_in = 1'b1;
            nonempty_in = 1'b1;
            hex_err_in  = hex_err_ff || !digit[4];
            if (!have_high_ff) begin
               high_in      = digit[3:0];
               have_high_in = 1'b1;
            end else begin
               have_high_in = 1'b0;
               if (!hex_err_in) begin
                  has_result = 1'b1;
                  if (dec_byte < BYTE_LOW_LIMIT || dec_byte > BYTE_HIGH_LIMIT ||
                      dec_byte == BYTE_QUOTE) begin
                     enc_in = 1'b1;
                  end
                  if (dec_byte == 8'h00) begin
                     dec_byte = BYTE_TAB;
                  end
                  result.out_byte = dec_byte;

                  // UTF-8 well-formedness: a continuation byte is checked
                  // against the range its lead byte allows; a bad one flags
                  // an error and is then parsed again as a lead byte.
                  if (pend_ff != 2'd0) begin
                     unique case (rule_ff)
                        RULE_A0_BF: lo_bound = 8'ha0;
                        RULE_80_9F: hi_bound = 8'h9f;
                        RULE_90_BF: lo_bound = 8'h90;
                        RULE_80_8F: hi_bound = 8'h8f;
                        default:    ;
                     endcase
                     rule_in = RULE_NONE;
                     if (dec_byte < lo_bound || dec_byte > hi_bound) begin
                        utf_err_in = 1'b1;
                        pend_in    = 2'd0;
                        as_lead    = 1'b1;
                     end else begin
                        pend_in = pend_ff - 2'd1;
                     end
                  end else begin
                     as_lead = 1'b1;
                  end
                  if (as_lead) begin
                     priority if (dec_byte <= 8'h7f) begin
                        pend_in = pend_in;
                     end else if (dec_byte >= 8'hc2 && dec_byte <= 8'hdf) begin
                        pend_in = 2'd1;
                     end else if (dec_byte >= 8'he0 && dec_byte <= 8'hef) begin
                        pend_in = 2'd2;
                        rule_in = (dec_byte == 8'he0) ? RULE_A0_BF :
                                  (dec_byte == 8'hed) ? RULE_80_9F : RULE_NONE;
                     end else if (dec_byte >= 8'hf0 && dec_byte <= 8'hf4) begin
                        pend_in = 2'd3;
                        rule_in = (dec_byte == 8'hf0) ? RULE_90_BF :
                                  (dec_byte == 8'hf4) ? RULE_80_8F : RULE_NONE;
                     end else begin
                        utf_err_in = 1'b1;
                     end
                  end
               end
            end
         end
         KIND_END: begin
            for (int i = 0; i < NUM_NAMES; i++) begin
               if (cand_ff[i] && key_pos_ff == NAME_LEN[i]) begin
                  matched = 1'b1;
               end
            end
            if (a_digit_ff && key_pos_ff >= 4'd2) begin
               matched = 1'b1;
            end
            has_result        = 1'b1;
            result.is_verdict = 1'b1;
            result.accepted   = matched && !in_data_ff.quoted && nonempty_ff &&
                                !have_high_ff && !hex_err_ff && enc_ff &&
                                !utf_err_ff && pend_ff == 2'd0;
            cand_in      = '1;
            key_pos_in   = 4'd0;
            a_digit_in   = 1'b0;
            in_value_in  = 1'b0;
            high_in      = 4'd0;
            have_high_in = 1'b0;
            nonempty_in  = 1'b0;
            hex_err_in   = 1'b0;
            enc_in       = 1'b0;
            pend_in      = 2'd0;
            rule_in      = RULE_NONE;
            utf_err_in   = 1'b0;
         end
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = has_result;
         out_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff   <= in_data_in;
      skid_data_ff <= skid_data_in;
      out_data_ff  <= out_data_in;
      if (reset) begin
         in_valid_ff   <= 1'b0;
         skid_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         cand_ff       <= '1;
         key_pos_ff    <= 4'd0;
         a_digit_ff    <= 1'b0;
         in_value_ff   <= 1'b0;
         high_ff       <= 4'd0;
         have_high_ff  <= 1'b0;
         nonempty_ff   <= 1'b0;
         hex_err_ff    <= 1'b0;
         enc_ff        <= 1'b0;
         pend_ff       <= 2'd0;
         rule_ff       <= RULE_NONE;
         utf_err_ff    <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         skid_valid_ff <= skid_valid_in;
         out_valid_ff  <= out_valid_in;
         if (advance) begin
            cand_ff      <= cand_in;
            key_pos_ff   <= key_pos_in;
            a_digit_ff   <= a_digit_in;
            in_value_ff  <= in_value_in;
            high_ff      <= high_in;
            have_high_ff <= have_high_in;
            nonempty_ff  <= nonempty_in;
            hex_err_ff   <= hex_err_in;
            enc_ff       <= enc_in;
            pend_ff      <= pend_in;
            rule_ff      <= rule_in;
            utf_err_ff   <= utf_err_in;
         end
      end
   end

   // The skid register only fills behind a full input register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> in_valid_ff)
      else $error("skid register full while input register is empty");

   // A continuation-byte restriction only exists while bytes are pending.
   assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd0 |-> rule_ff == RULE_NONE)
      else $error("UTF-8 rule set with no bytes pending");

   // A half-collected hex pair implies the value has started.
   assert property (@(posedge clock) disable iff (reset)
      have_high_ff |-> (in_value_ff && nonempty_ff))
      else $error("high nibble held outside a value");

   // A verdict leaves the parser at the start of a new key.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.req_type == KIND_END) |=>
         (key_pos_ff == 4'd0 && !in_value_ff && cand_ff == '1))
      else $error("parser state not cleared after verdict");

endmodule
